// ----- design/aspsmp_pkg.sv -----
// Package for the annular sector point sampler: widths, CORDIC constants,
// atan table and shared types. No dependencies.
`timescale 1ns / 1ps
package aspsmp_pkg;

  localparam int RAND_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int UW                = 16;
  localparam int CW                = 32;
  localparam int AW                = 20;
  // angle and vector datapath width (Q30 with sign and headroom)
  localparam int ZW                = 36;
  localparam longint Q30_PI        = 64'd3373259426;
  localparam longint Q30_HALF_PI   = 64'd1686629713;
  localparam longint Q30_TWO_PI    = 64'd6746518852;
  localparam longint CORDIC_K      = 64'd652032874;

  // register indexes
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_MIN_RADIUS = 3'd2;
  localparam logic [2:0] REG_MAX_RADIUS = 3'd3;
  localparam logic [2:0] REG_MIN_THETA  = 3'd4;
  localparam logic [2:0] REG_MAX_THETA  = 3'd5;
  localparam logic [2:0] REG_EDGE_MODE  = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [CW-1:0]        min_radius;
    logic [CW-1:0]        max_radius;
    logic signed [AW-1:0] min_theta;
    logic signed [AW-1:0] max_theta;
    logic                 edge_mode;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 36'sd843314857;   1: r = 36'sd497837829;
      2: r = 36'sd263043837;   3: r = 36'sd133525159;
      4: r = 36'sd67021687;    5: r = 36'sd33543516;
      6: r = 36'sd16775851;    7: r = 36'sd8388437;
      8: r = 36'sd4194283;     9: r = 36'sd2097149;
      default: r = (i >= 31) ? 36'sd0 : (36'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage

// ----- design/aspsmp_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Uses aspsmp_pkg.
`timescale 1ns / 1ps
module aspsmp_sqrt import aspsmp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [UW-1:0] frac,
  output logic [30:0] root
);
  // radicand = frac << (60-FRAC_BITS); root < 2^31 is 31 bits
  localparam int NB = 31;
  logic [61:0] rad [0:NB];
  logic [62:0] rem [0:NB];
  logic [30:0] res [0:NB];

  always_comb begin
    rad[0] = 62'(frac) << (60 - FRAC_BITS);
    rem[0] = '0;
    res[0] = '0;
  end

  // each stage brings in two radicand bits and decides one root bit
  for (genvar k = 0; k < NB; k++) begin : g_st
    logic [62:0] trial, rem_sh;
    always_comb begin
      rem_sh = {rem[k][60:0], rad[k][61:60]};
      trial  = {30'd0, res[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k] << 2;
        if (rem_sh >= trial) begin
          rem[k+1] <= rem_sh - trial;
          res[k+1] <= {res[k][29:0], 1'b1};
        end else begin
          rem[k+1] <= rem_sh;
          res[k+1] <= {res[k][29:0], 1'b0};
        end
      end
    end
  end

  assign root = res[NB];
endmodule

// ----- design/aspsmp_cordic.sv -----
// Pipelined rotation-mode CORDIC giving Q30 cos and sin, one registered stage per iteration.
// Uses aspsmp_pkg.
`timescale 1ns / 1ps
module aspsmp_cordic import aspsmp_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] angle,
  input  logic                 neg,
  output logic signed [ZW-1:0] cos_q30,
  output logic signed [ZW-1:0] sin_q30
);
  localparam int N = CORDIC_STAGES;
  logic signed [ZW-1:0] x [0:N];
  logic signed [ZW-1:0] y [0:N];
  logic signed [ZW-1:0] z [0:N];
  logic                 ng [0:N];

  always_comb begin
    x[0] = ZW'(CORDIC_K);
    y[0] = '0;
    z[0] = angle;
    ng[0] = neg;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q30(i);
        end
      end
    end
  end

  assign cos_q30 = ng[N] ? -x[N] : x[N];
  assign sin_q30 = ng[N] ? -y[N] : y[N];
endmodule

// ----- design/annulus_sector_point_sampler.sv -----
// Top level of the annular sector point sampler: config registers, angle
// and radius front end, sqrt and CORDIC pipes, multiply and saturate back end.
// Depends on aspsmp_pkg, aspsmp_sqrt, aspsmp_cordic.
//
//  channel | dir | handshake       | payload
//  s_axis  | in  | tvalid/tready   | tdata: u_theta, u_radius, u_pick
//  m_axis  | out | tvalid/tready   | tdata: point_x, point_y
//  cfg     | in  | valid/ready     | index (3b), data (32b)
//
// One item per cycle while m_axis is not stalled; the pipe depth is set by
// the bit-per-stage square root or the CORDIC pipe, whichever is deeper.
// rst clears valid bits and loads the register reset values.
// A stall on m_axis freezes the whole pipe; s_axis_tready follows the
// output side (valid bits and data move together, nothing is lost).
`timescale 1ns / 1ps
module annulus_sector_point_sampler import aspsmp_pkg::*; #(
  parameter int RAND_BITS     = RAND_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // u_theta, u_radius, u_pick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // point_x, point_y
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int FB  = (RAND_BITS > 16) ? 16 : RAND_BITS;
  localparam int SQL = 31;
  localparam int MID = (SQL > CORDIC_STAGES) ? SQL : CORDIC_STAGES;
  localparam int PIPE = MID + 7;

  cfg_t cfg;
  logic en;
  logic [PIPE-1:0] vld;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{center_x: '0, center_y: '0, min_radius: '0, max_radius: 32'd65536,
               min_theta: '0, max_theta: 20'sd411775, edge_mode: 1'b0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:   cfg.center_x   <= cfg_data;
        REG_CENTER_Y:   cfg.center_y   <= cfg_data;
        REG_MIN_RADIUS: cfg.min_radius <= cfg_data;
        REG_MAX_RADIUS: cfg.max_radius <= cfg_data;
        REG_MIN_THETA:  cfg.min_theta  <= cfg_data[AW-1:0];
        REG_MAX_THETA:  cfg.max_theta  <= cfg_data[AW-1:0];
        REG_EDGE_MODE:  cfg.edge_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipe moves when the output register is free or being taken
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PIPE-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld[PIPE-1];

  // stage 1: fractions, spans, edge pick products
  logic [FB-1:0] gt, gr, gp;
  assign gt = s_axis_tdata[15 -: FB];
  assign gr = s_axis_tdata[31 -: FB];
  assign gp = s_axis_tdata[47 -: FB];
  logic signed [AW:0]    span;
  logic [32:0]           rsum;
  assign span = AW'(0) + cfg.max_theta - cfg.min_theta;
  assign rsum = {1'b0, cfg.min_radius} + {1'b0, cfg.max_radius};

  logic signed [AW+FB+1:0] s1_tprod;
  logic [FB+32:0]          s1_pprod;
  logic                    s1_pick_ok;
  logic [FB-1:0]           s1_gr;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_tprod   <= $signed({1'b0, gt}) * span;
      s1_pprod   <= gp * rsum;
      s1_pick_ok <= (span != 0) && (rsum != 0);
      s1_gr      <= gr;
    end
  end

  // stage 2: theta in Q16, range reduce, edge decision
  logic signed [AW+1:0] theta;
  logic signed [ZW+1:0] a0, a1;
  logic signed [ZW-1:0] ang;
  logic                 fold;
  logic                 inner;
  assign theta = (AW+2)'(s1_tprod >>> FB) + cfg.min_theta;
  always_comb begin
    a0 = (ZW+2)'(theta) <<< 14;
    if (a0 > Q30_PI) a1 = a0 - (ZW+2)'(Q30_TWO_PI);
    else if (a0 < -Q30_PI) a1 = a0 + (ZW+2)'(Q30_TWO_PI);
    else a1 = a0;
    fold = 1'b0;
    if (a1 > Q30_HALF_PI) begin a1 = a1 - (ZW+2)'(Q30_PI); fold = 1'b1; end
    else if (a1 < -Q30_HALF_PI) begin a1 = a1 + (ZW+2)'(Q30_PI); fold = 1'b1; end
    ang = ZW'(a1);
    inner = s1_pick_ok && (s1_pprod < ({1'b0, cfg.min_radius} << FB));
  end

  logic signed [ZW-1:0] s2_ang;
  logic                 s2_fold, s2_inner;
  logic [FB-1:0]        s2_gr;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ang <= ang; s2_fold <= fold; s2_inner <= inner; s2_gr <= s1_gr;
    end
  end

  // middle: sqrt and CORDIC in parallel, delayed to the same depth
  logic [30:0] root;
  logic signed [ZW-1:0] c_raw, s_raw;
  aspsmp_sqrt #(.FRAC_BITS(FB)) u_sqrt (
    .clk(clk), .en(en), .frac(UW'(s2_gr)), .root(root));
  aspsmp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .en(en), .angle(s2_ang), .neg(s2_fold), .cos_q30(c_raw), .sin_q30(s_raw));

  logic [30:0]          root_d [0:MID-SQL];
  logic signed [ZW-1:0] c_d [0:MID-CORDIC_STAGES];
  logic signed [ZW-1:0] s_d [0:MID-CORDIC_STAGES];
  logic                 inner_d [0:MID];
  assign root_d[0] = root;
  assign c_d[0] = c_raw;
  assign s_d[0] = s_raw;
  assign inner_d[0] = s2_inner;
  for (genvar k = 0; k < MID - SQL; k++) begin : g_rd
    always_ff @(posedge clk) if (en) root_d[k+1] <= root_d[k];
  end
  for (genvar k = 0; k < MID - CORDIC_STAGES; k++) begin : g_cd
    always_ff @(posedge clk) if (en) begin
      c_d[k+1] <= c_d[k]; s_d[k+1] <= s_d[k];
    end
  end
  for (genvar k = 0; k < MID; k++) begin : g_id
    always_ff @(posedge clk) if (en) inner_d[k+1] <= inner_d[k];
  end

  // stage 3: sqrt times radius span
  logic signed [33:0] rspan;
  assign rspan = $signed({2'b0, cfg.max_radius}) - $signed({2'b0, cfg.min_radius});
  logic signed [65:0]   s3_rprod;
  logic signed [ZW-1:0] s3_c, s3_s;
  logic                 s3_inner;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_rprod <= $signed({1'b0, root_d[MID-SQL]}) * rspan;
      s3_c <= c_d[MID-CORDIC_STAGES]; s3_s <= s_d[MID-CORDIC_STAGES];
      s3_inner <= inner_d[MID];
    end
  end

  // stage 4: select radius
  logic [32:0] s4_rad;
  logic signed [ZW-1:0] s4_c, s4_s;
  always_ff @(posedge clk) begin
    if (en) begin
      if (cfg.edge_mode) s4_rad <= s3_inner ? {1'b0, cfg.min_radius} : {1'b0, cfg.max_radius};
      else s4_rad <= 33'($signed({1'b0, cfg.min_radius}) + (s3_rprod >>> 30));
      s4_c <= s3_c; s4_s <= s3_s;
    end
  end

  // stage 5: radius times cos and sin
  logic signed [ZW+33:0] s5_px, s5_py;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_px <= $signed({1'b0, s4_rad}) * s4_c;
      s5_py <= $signed({1'b0, s4_rad}) * s4_s;
    end
  end

  // stage 6: round, add centre
  logic signed [ZW+4:0] s6_x, s6_y;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_x <= (ZW+5)'((s5_px + (70'sd1 <<< 29)) >>> 30) + cfg.center_x;
      s6_y <= (ZW+5)'((s5_py + (70'sd1 <<< 29)) >>> 30) + cfg.center_y;
    end
  end

  // stage 7: saturate into the output register
  function automatic logic [31:0] sat(input logic signed [ZW+4:0] v);
    if (v > 41'sd2147483647) return 32'h7fffffff;
    if (v < -41'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= {sat(s6_y), sat(s6_x)};
  end
endmodule

// ----- design/aspsmp_checker.sv -----
// Port-level checker for the sampler, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
module aspsmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipe frozen");
  a_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with empty output");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

bind annulus_sector_point_sampler aspsmp_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));
